>>> rtl/core/sfpld_pkg.sv
// Package for the serial frame parser: register codes, phase codes and reset values.
`default_nettype none
package sfpld_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned NibW   = 4;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] REG_HEADER_BYTE   = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_LEVEL_COMMAND = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_LEVEL_OFFSET  = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_LEVEL_FULL    = 2'd3;

  localparam logic [1:0] PHASE_HUNT    = 2'd0;
  localparam logic [1:0] PHASE_CMD     = 2'd1;
  localparam logic [1:0] PHASE_PAYLOAD = 2'd2;
  localparam logic [1:0] PHASE_CHECK   = 2'd3;

  localparam logic [ByteW-1:0] HEADER_RESET        = 8'hCC;
  localparam logic [NibW-1:0]  LEVEL_COMMAND_RESET = 4'd1;
  localparam logic [NibW-1:0]  LEVEL_OFFSET_RESET  = 4'd1;
  localparam logic [ByteW-1:0] LEVEL_FULL_RESET    = 8'd30;
  localparam logic [ByteW-1:0] CHECK_SEED          = 8'd1;

endpackage
`default_nettype wire

>>> rtl/core/serial_frame_parser_level_decode.sv
// Serial frame parser: header hunt, command/length, payload sum, checksum and level decode.
`default_nettype none
// One received byte is taken per cycle and updates the parser state in that same
// cycle; the checksum byte of a frame loads one result beat into the output
// register, which appears on the next cycle. Only checksum bytes wait on a full,
// stalled output register; every other byte is taken each cycle, so the rate is
// one byte per clock unless the output stalls. Configuration registers are written
// through cfg_write/cfg_index/cfg_data and should change only while no frame is open.
module serial_frame_parser_level_decode (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_write,
  input  wire logic [sfpld_pkg::CfgIdxW-1:0] cfg_index,
  input  wire logic [sfpld_pkg::ByteW-1:0] cfg_data,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [sfpld_pkg::ByteW-1:0] rx_byte,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [sfpld_pkg::NibW-1:0]       frame_command,
  output logic [sfpld_pkg::NibW-1:0]       payload_length,
  output logic                             checksum_ok,
  output logic                             level_valid,
  output logic [sfpld_pkg::ByteW-1:0]      level_value
);

  logic [sfpld_pkg::ByteW-1:0] header_byte;
  logic [sfpld_pkg::NibW-1:0]  level_command;
  logic [sfpld_pkg::NibW-1:0]  level_offset;
  logic [sfpld_pkg::ByteW-1:0] level_full;

  logic [1:0]                  parse_phase;
  logic [1:0]                  parse_phase_next;
  logic [sfpld_pkg::NibW-1:0]  command_held;
  logic [sfpld_pkg::NibW-1:0]  length_held;
  logic [sfpld_pkg::NibW-1:0]  payload_count;
  logic [sfpld_pkg::NibW-1:0]  payload_count_inc;
  logic [sfpld_pkg::ByteW-1:0] running_sum;
  logic [sfpld_pkg::ByteW-1:0] level_raw;
  logic [sfpld_pkg::ByteW-1:0] level_last;

  logic                        in_accept;
  logic                        check_ok;
  logic                        check_valid;
  logic [sfpld_pkg::ByteW-1:0] level_clamped;
  logic [sfpld_pkg::ByteW-1:0] level_decoded;

  always_ff @(posedge clk) begin
    if (rst) begin
      header_byte   <= sfpld_pkg::HEADER_RESET;
      level_command <= sfpld_pkg::LEVEL_COMMAND_RESET;
      level_offset  <= sfpld_pkg::LEVEL_OFFSET_RESET;
      level_full    <= sfpld_pkg::LEVEL_FULL_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        sfpld_pkg::REG_HEADER_BYTE:   header_byte   <= cfg_data;
        sfpld_pkg::REG_LEVEL_COMMAND: level_command <= cfg_data[sfpld_pkg::NibW-1:0];
        sfpld_pkg::REG_LEVEL_OFFSET:  level_offset  <= cfg_data[sfpld_pkg::NibW-1:0];
        sfpld_pkg::REG_LEVEL_FULL:    level_full    <= cfg_data;
        default: ;
      endcase
    end
  end

  // stall only a checksum beat that has nowhere to go
  assign in_stall  = out_valid && out_stall && (parse_phase == sfpld_pkg::PHASE_CHECK);
  assign in_accept = in_valid && !in_stall;

  assign payload_count_inc = payload_count + 4'd1;
  assign check_ok      = ((sfpld_pkg::CHECK_SEED - running_sum) == rx_byte);
  assign check_valid   = check_ok && (command_held == level_command)
                         && (level_offset < length_held);
  assign level_clamped = (level_raw > level_full) ? level_full : level_raw;
  assign level_decoded = check_valid ? (level_full - level_clamped) : level_last;

  always_comb begin
    parse_phase_next = parse_phase;
    unique case (parse_phase)
      sfpld_pkg::PHASE_HUNT: begin
        if (rx_byte == header_byte) begin
          parse_phase_next = sfpld_pkg::PHASE_CMD;
        end
      end
      sfpld_pkg::PHASE_CMD: begin
        parse_phase_next = (rx_byte[sfpld_pkg::NibW-1:0] == '0) ?
                           sfpld_pkg::PHASE_CHECK : sfpld_pkg::PHASE_PAYLOAD;
      end
      sfpld_pkg::PHASE_PAYLOAD: begin
        if (payload_count_inc == length_held) begin
          parse_phase_next = sfpld_pkg::PHASE_CHECK;
        end
      end
      sfpld_pkg::PHASE_CHECK: begin
        parse_phase_next = sfpld_pkg::PHASE_HUNT;
      end
      default: parse_phase_next = sfpld_pkg::PHASE_HUNT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase   <= sfpld_pkg::PHASE_HUNT;
      command_held  <= '0;
      length_held   <= '0;
      payload_count <= '0;
      running_sum   <= '0;
      level_raw     <= '0;
      level_last    <= '0;
    end else if (in_accept) begin
      parse_phase <= parse_phase_next;
      unique case (parse_phase)
        sfpld_pkg::PHASE_HUNT: begin
          if (rx_byte == header_byte) begin
            running_sum   <= rx_byte;
            level_raw     <= '0;
            payload_count <= '0;
          end
        end
        sfpld_pkg::PHASE_CMD: begin
          command_held  <= rx_byte[sfpld_pkg::ByteW-1:sfpld_pkg::NibW];
          length_held   <= rx_byte[sfpld_pkg::NibW-1:0];
          running_sum   <= running_sum + rx_byte;
          payload_count <= '0;
        end
        sfpld_pkg::PHASE_PAYLOAD: begin
          if (payload_count == level_offset) begin
            level_raw <= rx_byte;
          end
          running_sum   <= running_sum + rx_byte;
          payload_count <= payload_count_inc;
        end
        sfpld_pkg::PHASE_CHECK: begin
          level_last <= level_decoded;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept && (parse_phase == sfpld_pkg::PHASE_CHECK)) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && (parse_phase == sfpld_pkg::PHASE_CHECK)) begin
      frame_command  <= command_held;
      payload_length <= length_held;
      checksum_ok    <= check_ok;
      level_valid    <= check_valid;
      level_value    <= level_decoded;
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    !(in_accept && (parse_phase == sfpld_pkg::PHASE_CHECK) && out_valid && out_stall))
    else $error("result beat overwritten while stalled");

  a_check_gives_beat: assert property (@(posedge clk) disable iff (rst)
    in_accept && (parse_phase == sfpld_pkg::PHASE_CHECK) |=> out_valid)
    else $error("checksum byte gave no result beat");

  a_level_needs_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && level_valid |-> checksum_ok)
    else $error("level flagged valid on failed checksum");

  a_count_in_range: assert property (@(posedge clk) disable iff (rst)
    (parse_phase == sfpld_pkg::PHASE_PAYLOAD) |-> (payload_count < length_held))
    else $error("payload count ran past frame length");

  a_zero_length: assert property (@(posedge clk) disable iff (rst)
    in_accept && (parse_phase == sfpld_pkg::PHASE_CMD)
    && (rx_byte[sfpld_pkg::NibW-1:0] == '0) |=> (parse_phase == sfpld_pkg::PHASE_CHECK))
    else $error("zero-length frame did not go to checksum");

endmodule
`default_nettype wire

>>> sim/serial_frame_parser_level_decode_tb.sv
// Testbench for the serial frame parser: byte stream stimulus, frame prediction and result checks.
module serial_frame_parser_level_decode_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [sfpld_pkg::NibW-1:0]  command;
    logic [sfpld_pkg::NibW-1:0]  length;
    logic                        sum_ok;
    logic                        level_ok;
    logic [sfpld_pkg::ByteW-1:0] level;
  } frame_result_t;

  logic                          clk;
  logic                          rst;
  logic                          cfg_write;
  logic [sfpld_pkg::CfgIdxW-1:0] cfg_index;
  logic [sfpld_pkg::ByteW-1:0]   cfg_data;
  logic                          in_valid;
  logic                          in_stall;
  logic [sfpld_pkg::ByteW-1:0]   rx_byte;
  logic                          out_valid;
  logic                          out_stall;
  logic [sfpld_pkg::NibW-1:0]    frame_command;
  logic [sfpld_pkg::NibW-1:0]    payload_length;
  logic                          checksum_ok;
  logic                          level_valid;
  logic [sfpld_pkg::ByteW-1:0]   level_value;

  serial_frame_parser_level_decode i_dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .rx_byte        (rx_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .frame_command  (frame_command),
    .payload_length (payload_length),
    .checksum_ok    (checksum_ok),
    .level_valid    (level_valid),
    .level_value    (level_value)
  );

  // parser copy
  logic [sfpld_pkg::ByteW-1:0] hdr_q;
  logic [sfpld_pkg::NibW-1:0]  lvl_cmd_q;
  logic [sfpld_pkg::NibW-1:0]  lvl_off_q;
  logic [sfpld_pkg::ByteW-1:0] lvl_full_q;
  logic [1:0]                  phase_q;
  logic [sfpld_pkg::NibW-1:0]  cmd_q;
  logic [sfpld_pkg::NibW-1:0]  len_q;
  logic [sfpld_pkg::NibW-1:0]  count_q;
  logic [sfpld_pkg::ByteW-1:0] sum_q;
  logic [sfpld_pkg::ByteW-1:0] raw_q;
  logic [sfpld_pkg::ByteW-1:0] last_q;

  frame_result_t               pending_frames[$];
  logic [sfpld_pkg::ByteW-1:0] body_bytes [16];
  int                          errors;
  int                          frame_bytes;
  int                          burst_left;
  bit                          sender_gapless;
  int                          hold_requests;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // receiver: random stall segments plus long hold-offs on request
  initial begin : receiver
    int hold_served;
    int hold_left;
    int seg_left;
    int stall_mode;
    hold_served = 0;
    hold_left = 0;
    seg_left = 0;
    stall_mode = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_served != hold_requests) begin
        hold_served = hold_requests;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (seg_left == 0) begin
          seg_left = $urandom_range(16, 128);
          stall_mode = $urandom_range(0, 2);
        end
        seg_left--;
        case (stall_mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          default: out_stall <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin : check_results
    frame_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_frames.size() == 0) begin
        $error("result beat with no frame pending");
        errors++;
      end else begin
        want = pending_frames.pop_front();
        if (frame_command !== want.command) begin
          $error("frame_command: expected %0d, got %0d", want.command, frame_command);
          errors++;
        end
        if (payload_length !== want.length) begin
          $error("payload_length: expected %0d, got %0d", want.length, payload_length);
          errors++;
        end
        if (checksum_ok !== want.sum_ok) begin
          $error("checksum_ok: expected %0d, got %0d", want.sum_ok, checksum_ok);
          errors++;
        end
        if (level_valid !== want.level_ok) begin
          $error("level_valid: expected %0d, got %0d", want.level_ok, level_valid);
          errors++;
        end
        if (level_value !== want.level) begin
          $error("level_value: expected %0d, got %0d", want.level, level_value);
          errors++;
        end
      end
    end
  end

  task automatic reset_parser_copy();
    hdr_q = sfpld_pkg::HEADER_RESET;
    lvl_cmd_q = sfpld_pkg::LEVEL_COMMAND_RESET;
    lvl_off_q = sfpld_pkg::LEVEL_OFFSET_RESET;
    lvl_full_q = sfpld_pkg::LEVEL_FULL_RESET;
    phase_q = sfpld_pkg::PHASE_HUNT;
    cmd_q = '0;
    len_q = '0;
    count_q = '0;
    sum_q = '0;
    raw_q = '0;
    last_q = '0;
  endtask

  task automatic parse_rx_byte(input logic [sfpld_pkg::ByteW-1:0] b);
    frame_result_t res;
    logic [sfpld_pkg::ByteW-1:0] want_sum;
    logic [sfpld_pkg::ByteW-1:0] clamped;
    case (phase_q)
      sfpld_pkg::PHASE_HUNT: begin
        if (b == hdr_q) begin
          sum_q = b;
          raw_q = '0;
          count_q = '0;
          phase_q = sfpld_pkg::PHASE_CMD;
        end
      end
      sfpld_pkg::PHASE_CMD: begin
        cmd_q = b[7:4];
        len_q = b[3:0];
        sum_q = sum_q + b;
        count_q = '0;
        phase_q = (b[3:0] == '0) ? sfpld_pkg::PHASE_CHECK : sfpld_pkg::PHASE_PAYLOAD;
      end
      sfpld_pkg::PHASE_PAYLOAD: begin
        if (count_q == lvl_off_q) raw_q = b;
        sum_q = sum_q + b;
        count_q = count_q + 1'b1;
        if (count_q == len_q) phase_q = sfpld_pkg::PHASE_CHECK;
      end
      default: begin
        want_sum = sfpld_pkg::CHECK_SEED - sum_q;
        res.command = cmd_q;
        res.length = len_q;
        res.sum_ok = (want_sum == b);
        res.level_ok = res.sum_ok && (cmd_q == lvl_cmd_q) && (lvl_off_q < len_q);
        if (res.level_ok) begin
          clamped = (raw_q > lvl_full_q) ? lvl_full_q : raw_q;
          last_q = lvl_full_q - clamped;
        end
        res.level = last_q;
        pending_frames.push_back(res);
        phase_q = sfpld_pkg::PHASE_HUNT;
      end
    endcase
  endtask

  task automatic send_byte(input logic [sfpld_pkg::ByteW-1:0] b);
    int gap;
    if (!sender_gapless) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 32);
        gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        repeat (gap) begin
          @(negedge clk);
          in_valid <= 1'b0;
        end
      end
      burst_left--;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (phase_q != sfpld_pkg::PHASE_HUNT || b == hdr_q) frame_bytes++;
    parse_rx_byte(b);
  endtask

  task automatic send_frame(input logic [sfpld_pkg::NibW-1:0] cmd,
                            input logic [sfpld_pkg::NibW-1:0] len,
                            input bit good_sum);
    logic [sfpld_pkg::ByteW-1:0] sum;
    logic [sfpld_pkg::ByteW-1:0] chk;
    sum = hdr_q + {cmd, len};
    send_byte(hdr_q);
    send_byte({cmd, len});
    for (int i = 0; i < len; i++) begin
      sum = sum + body_bytes[i];
      send_byte(body_bytes[i]);
    end
    chk = sfpld_pkg::CHECK_SEED - sum;
    if (!good_sum) chk = chk ^ 8'($urandom_range(1, 255));
    send_byte(chk);
  endtask

  task automatic fill_body();
    for (int i = 0; i < 16; i++) body_bytes[i] = 8'($urandom_range(0, 255));
    case ($urandom_range(0, 5))
      0: body_bytes[lvl_off_q] = 8'h00;
      1: body_bytes[lvl_off_q] = lvl_full_q;
      2: body_bytes[lvl_off_q] = lvl_full_q + 8'd1;
      3: body_bytes[lvl_off_q] = lvl_full_q - 8'd1;
      4: body_bytes[lvl_off_q] = 8'hFF;
      default: ;
    endcase
  endtask

  task automatic close_frame();
    while (phase_q != sfpld_pkg::PHASE_HUNT) send_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic settle();
    close_frame();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_frames.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apply_settings(input logic [sfpld_pkg::ByteW-1:0] hdr,
                                input logic [sfpld_pkg::NibW-1:0] cmd,
                                input logic [sfpld_pkg::NibW-1:0] off,
                                input logic [sfpld_pkg::ByteW-1:0] full);
    logic [sfpld_pkg::ByteW-1:0] vals [4];
    logic [sfpld_pkg::CfgIdxW-1:0] idx;
    vals[sfpld_pkg::REG_HEADER_BYTE] = hdr;
    vals[sfpld_pkg::REG_LEVEL_COMMAND] = {4'($urandom_range(0, 15)), cmd};
    vals[sfpld_pkg::REG_LEVEL_OFFSET] = {4'($urandom_range(0, 15)), off};
    vals[sfpld_pkg::REG_LEVEL_FULL] = full;
    for (int i = 0; i < 4; i++) begin
      idx = sfpld_pkg::CfgIdxW'(i);
      @(negedge clk);
      cfg_write <= 1'b1;
      cfg_index <= idx;
      cfg_data <= vals[i];
      @(posedge clk);
      case (idx)
        sfpld_pkg::REG_HEADER_BYTE:   hdr_q = vals[i];
        sfpld_pkg::REG_LEVEL_COMMAND: lvl_cmd_q = vals[i][3:0];
        sfpld_pkg::REG_LEVEL_OFFSET:  lvl_off_q = vals[i][3:0];
        default:                      lvl_full_q = vals[i];
      endcase
    end
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic test_zero_length_frame();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_frame(4'h0, 4'h0, 1'b1);
    settle();
  endtask

  task automatic test_level_decode();
    body_bytes[0] = 8'h3C;
    body_bytes[1] = 8'h0A;
    send_frame(lvl_cmd_q, 4'h2, 1'b1);
    settle();
  endtask

  task automatic test_failed_checksum();
    body_bytes[0] = 8'h55;
    send_frame(lvl_cmd_q, 4'h1, 1'b0);
    settle();
  endtask

  task automatic test_long_frame();
    apply_settings(sfpld_pkg::HEADER_RESET, 4'hF, 4'd14, 8'd200);
    for (int i = 0; i < 16; i++) body_bytes[i] = 8'($urandom_range(0, 255));
    body_bytes[3] = sfpld_pkg::HEADER_RESET;
    body_bytes[5] = 8'h00;
    body_bytes[14] = 8'hFF;
    send_frame(4'hF, 4'hF, 1'b1);
    settle();
  endtask

  task automatic test_output_backpressure();
    sender_gapless = 1'b1;
    hold_requests++;
    repeat (10) begin
      fill_body();
      send_frame(lvl_cmd_q, 4'($urandom_range(0, 3)), 1'b1);
    end
    sender_gapless = 1'b0;
    settle();
  endtask

  task automatic run_random_frames(input int count);
    int stop_at;
    logic [sfpld_pkg::NibW-1:0] cmd;
    logic [sfpld_pkg::NibW-1:0] len;
    stop_at = frame_bytes + count;
    while (frame_bytes < stop_at) begin
      case ($urandom_range(0, 9))
        0: begin
          repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
          close_frame();
        end
        1: begin
          send_byte(hdr_q);
          close_frame();
        end
        default: begin
          cmd = ($urandom_range(0, 4) < 3) ? lvl_cmd_q : 4'($urandom_range(0, 15));
          case ($urandom_range(0, 7))
            0: len = 4'h0;
            1: len = 4'hF;
            default: len = 4'($urandom_range(0, 15));
          endcase
          fill_body();
          send_frame(cmd, len, $urandom_range(0, 7) != 0);
        end
      endcase
    end
    settle();
  endtask

  task automatic test_register_sweep();
    apply_settings(sfpld_pkg::HEADER_RESET, sfpld_pkg::LEVEL_COMMAND_RESET,
                   sfpld_pkg::LEVEL_OFFSET_RESET, sfpld_pkg::LEVEL_FULL_RESET);
    run_random_frames(125);
    apply_settings(8'h00, 4'h0, 4'd0, 8'd0);
    run_random_frames(125);
    apply_settings(8'hFF, 4'hF, 4'd14, 8'd255);
    run_random_frames(125);
    repeat (3) begin
      apply_settings(8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)),
                     4'($urandom_range(0, 14)), 8'($urandom_range(0, 255)));
      run_random_frames(125);
    end
  endtask

  initial begin
    errors = 0;
    frame_bytes = 0;
    burst_left = 0;
    sender_gapless = 1'b0;
    hold_requests = 0;
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    rx_byte = '0;
    reset_parser_copy();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_zero_length_frame();
    test_level_decode();
    test_failed_checksum();
    test_long_frame();
    test_output_backpressure();
    test_register_sweep();
    settle();

    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/sfpld_pkg.sv
rtl/core/serial_frame_parser_level_decode.sv
sim/serial_frame_parser_level_decode_tb.sv
